// ===== design/ccpd_pkg.sv =====
// ----------------------------------------------------------------------------
// ccpd_pkg : shared types and constants for the capture channel pattern DMA
// Register indices, status bits, item codes and the controller/datapath link.
// ----------------------------------------------------------------------------
`default_nettype none

package ccpd_pkg;

    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;
    localparam logic [1:0] FUNC_PIXEL = 2'd3;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_PIXEL = 2'd2;

    localparam logic [5:0] IDX_CTRL    = 6'd0;
    localparam logic [5:0] IDX_IMG_CFG = 6'd3;
    localparam logic [5:0] IDX_IER     = 6'd4;
    localparam logic [5:0] IDX_STS     = 6'd5;
    localparam logic [5:0] IDX_BUF1    = 6'd28;
    localparam logic [5:0] IDX_PITCH   = 6'd31;
    localparam logic [5:0] IDX_BUF2    = 6'd35;

    localparam logic [31:0] STS_FRAME_STORED = 32'h2000_0000;
    localparam logic [31:0] STS_BUF1_ACTIVE  = 32'h0000_0100;
    localparam logic [31:0] STS_BUF2_ACTIVE  = 32'h0000_0200;
    localparam logic [31:0] PIXEL_ALPHA      = 32'hff00_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_FINISH,
        ST_OUT
    } ccpd_state_t;

    // controller -> datapath
    typedef struct packed {
        logic exec;       // perform the captured item
        logic div_start;  // load the bytes-per-pixel divider
        logic div_step;   // one restoring step
        logic div_done;   // commit the quotient, frame goes busy
    } ccpd_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_div;   // tick accepted a non-empty frame
        logic div_last;   // final divider step this cycle
    } ccpd_sts_t;

endpackage

`default_nettype wire

// ===== design/ccpd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ccpd_ctrl : item sequencer
// Accepts an item, runs it, runs the divider for a frame start, then holds
// the result until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ccpd_ctrl
    import ccpd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  wire logic      out_stall,
    output ccpd_cmd_t      cmd,
    input  wire ccpd_sts_t sts
);

    ccpd_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (sts.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                cmd.div_done = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    in_stall = 1'b0;
                    state_next = in_valid ? ST_EXEC : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/ccpd_dp.sv =====
// ----------------------------------------------------------------------------
// ccpd_dp : register file, frame walker, divider and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module ccpd_dp
    import ccpd_pkg::*;
#(
    parameter int NUM_REGS = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_take,
    input  wire logic [1:0]  func,
    input  wire logic [5:0]  reg_index,
    input  wire logic [31:0] write_data,
    input  wire ccpd_cmd_t   cmd,
    output ccpd_sts_t        sts,
    output logic [1:0]       kind,
    output logic [31:0]      read_data,
    output logic [33:0]      dma_address,
    output logic [31:0]      pixel_value,
    output logic [2:0]       pixel_bytes,
    output logic             last_pixel,
    output logic             irq_level
);

    // register index field is 6 bits, so only the low 64 words are reachable
    localparam int NREACH = (NUM_REGS < 64) ? NUM_REGS : 64;
    localparam int AW     = $clog2(NREACH);

    // plain storage words; a valid flag per word makes unwritten words read 0
    logic [31:0]       mem [NREACH];
    logic [NREACH-1:0] mem_valid_reg;
    logic [31:0]       mem_rd_reg;

    // control registers kept in flops
    logic [31:0] ctrl_reg, cfg_reg, ier_reg, sts_reg, buf1_reg, pitch_cfg_reg, buf2_reg;

    // captured item
    logic [1:0]  func_reg;
    logic [5:0]  idx_reg;
    logic [31:0] data_reg;

    logic [31:0] count_reg;
    logic        busy_reg;
    logic [12:0] col_reg, row_reg, fw_reg, fh_reg;
    logic [15:0] bpp_reg, pitch_reg;
    logic [33:0] row_addr_reg;
    logic        second_reg;
    logic        irq_reg;

    // divider: 16-bit restoring, one bit a step
    logic [15:0] quo_reg;
    logic [13:0] rem_reg;
    logic [3:0]  dstep_reg;

    logic [31:0] sts_w, ier_w, ctrl_w, cfg_w, buf1_w, buf2_w, pitch_w;
    logic        in_range;
    logic [12:0] cfg_w_w, cfg_h_w;
    logic [15:0] cfg_p_w;
    logic        sec_w;
    logic [31:0] buf_w;
    logic        empty_w;
    logic [31:0] sts_done;
    logic [13:0] rem_sh;
    logic [13:0] rem_sub;
    logic [12:0] col_inc;
    logic [12:0] row_inc;
    logic        row_end, frame_end;
    logic [7:0]  pv;
    logic [49:0] col_off;
    logic [31:0] reg_rd_w;
    logic        plain_w;

    assign sts_w    = sts_reg;
    assign ier_w    = ier_reg;
    assign ctrl_w   = ctrl_reg;
    assign cfg_w    = cfg_reg;
    assign buf1_w   = buf1_reg;
    assign buf2_w   = buf2_reg;
    assign pitch_w  = pitch_cfg_reg;
    assign in_range = 32'(idx_reg) < 32'(NUM_REGS);

    assign cfg_w_w = cfg_w[12:0];
    assign cfg_h_w = cfg_w[28:16];
    assign cfg_p_w = pitch_w[15:0];
    assign sec_w   = count_reg[0];
    assign buf_w   = sec_w ? buf2_w : buf1_w;
    assign empty_w = (buf_w == '0) || (cfg_w_w == '0) || (cfg_h_w == '0) || (cfg_p_w == '0);

    assign sts.need_div = (func_reg == FUNC_TICK) && ctrl_w[31] && !busy_reg && !empty_w;
    assign sts.div_last = (dstep_reg == 4'd15);

    // register read mux: control registers or the registered storage word
    always_comb
    begin
        reg_rd_w = '0;
        plain_w  = 1'b0;
        case (idx_reg)
            IDX_CTRL:    reg_rd_w = ctrl_reg;
            IDX_IMG_CFG: reg_rd_w = cfg_reg;
            IDX_IER:     reg_rd_w = ier_reg;
            IDX_STS:     reg_rd_w = sts_reg;
            IDX_BUF1:    reg_rd_w = buf1_reg;
            IDX_PITCH:   reg_rd_w = pitch_cfg_reg;
            IDX_BUF2:    reg_rd_w = buf2_reg;
            default:
            begin
                plain_w  = 1'b1;
                reg_rd_w = mem_valid_reg[idx_reg[AW-1:0]] ? mem_rd_reg : '0;
            end
        endcase
    end

    // completion applied to status at the last pixel; empty frames build the same value inline
    always_comb
    begin
        sts_done = sts_w & ~(STS_BUF1_ACTIVE | STS_BUF2_ACTIVE);
        sts_done = sts_done | (second_reg ? STS_BUF1_ACTIVE : STS_BUF2_ACTIVE) | STS_FRAME_STORED;
    end

    assign rem_sh  = {rem_reg[12:0], quo_reg[15]};
    assign rem_sub = rem_sh - {1'b0, fw_reg};
    assign col_inc = col_reg + 13'd1;
    assign row_inc = row_reg + 13'd1;
    assign row_end = col_inc >= fw_reg;
    assign frame_end = row_end && (row_inc >= fh_reg);
    assign pv      = col_reg[7:0] + row_reg[7:0] + {count_reg[5:0], 2'b00};
    assign col_off = {37'd0, col_reg} * {34'd0, bpp_reg};

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            func_reg   <= func;
            idx_reg    <= reg_index;
            data_reg   <= write_data;
            // storage read at capture, used at execute
            mem_rd_reg <= mem[reg_index[AW-1:0]];
        end
        if (cmd.exec && (func_reg == FUNC_WRITE) && in_range && plain_w)
        begin
            mem[idx_reg[AW-1:0]] <= data_reg;
        end
        if (cmd.div_start)
        begin
            quo_reg   <= cfg_p_w;
            rem_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            if (!rem_sub[13])
            begin
                rem_reg <= rem_sub;
                quo_reg <= {quo_reg[14:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[14:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_valid_reg <= '0;
            ctrl_reg      <= '0;
            cfg_reg       <= '0;
            ier_reg       <= '0;
            sts_reg       <= '0;
            buf1_reg      <= '0;
            pitch_cfg_reg <= '0;
            buf2_reg      <= '0;
            count_reg    <= '0;
            busy_reg     <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
            fw_reg       <= '0;
            fh_reg       <= '0;
            bpp_reg      <= '0;
            pitch_reg    <= '0;
            row_addr_reg <= '0;
            second_reg   <= 1'b0;
            irq_reg      <= 1'b0;
            dstep_reg    <= '0;
            kind         <= KIND_NONE;
            read_data    <= '0;
            dma_address  <= '0;
            pixel_value  <= '0;
            pixel_bytes  <= '0;
            last_pixel   <= 1'b0;
        end
        else
        begin
            if (cmd.div_start)
            begin
                dstep_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                dstep_reg <= dstep_reg + 4'd1;
            end
            if (cmd.div_done)
            begin
                bpp_reg  <= (quo_reg != '0) ? quo_reg : 16'd4;
                busy_reg <= 1'b1;
            end
            if (cmd.exec)
            begin
                kind        <= KIND_NONE;
                read_data   <= '0;
                dma_address <= '0;
                pixel_value <= '0;
                pixel_bytes <= '0;
                last_pixel  <= 1'b0;
                case (func_reg)
                    FUNC_READ:
                    begin
                        kind <= KIND_READ;
                        if (in_range)
                        begin
                            read_data <= reg_rd_w;
                        end
                    end
                    FUNC_WRITE:
                    begin
                        if (in_range)
                        begin
                            if (idx_reg == IDX_STS)
                            begin
                                sts_reg <= sts_w & ~data_reg;
                                irq_reg <= ((sts_w & ~data_reg) & ier_w) != '0;
                            end
                            else
                            begin
                                case (idx_reg)
                                    IDX_CTRL:    ctrl_reg      <= data_reg;
                                    IDX_IMG_CFG: cfg_reg       <= data_reg;
                                    IDX_IER:     ier_reg       <= data_reg;
                                    IDX_BUF1:    buf1_reg      <= data_reg;
                                    IDX_PITCH:   pitch_cfg_reg <= data_reg;
                                    IDX_BUF2:    buf2_reg      <= data_reg;
                                    default:
                                    begin
                                        mem_valid_reg[idx_reg[AW-1:0]] <= 1'b1;
                                    end
                                endcase
                                if (idx_reg == IDX_CTRL)
                                begin
                                    if (data_reg[31] && !ctrl_w[31])
                                    begin
                                        count_reg <= '0;
                                    end
                                    else if (!data_reg[31])
                                    begin
                                        busy_reg <= 1'b0;
                                        irq_reg  <= 1'b0;
                                    end
                                end
                                else if (idx_reg == IDX_IER)
                                begin
                                    irq_reg <= (sts_w & data_reg) != '0;
                                end
                            end
                        end
                    end
                    FUNC_TICK:
                    begin
                        if (ctrl_w[31] && !busy_reg)
                        begin
                            fw_reg     <= cfg_w_w;
                            fh_reg     <= cfg_h_w;
                            pitch_reg  <= cfg_p_w;
                            second_reg <= sec_w;
                            col_reg    <= '0;
                            row_reg    <= '0;
                            row_addr_reg <= {2'b00, buf_w};
                            if (empty_w)
                            begin
                                // empty frame completes at once
                                sts_reg <= (sts_w & ~(STS_BUF1_ACTIVE | STS_BUF2_ACTIVE))
                                    | (sec_w ? STS_BUF1_ACTIVE : STS_BUF2_ACTIVE)
                                    | STS_FRAME_STORED;
                                irq_reg <= (((sts_w & ~(STS_BUF1_ACTIVE | STS_BUF2_ACTIVE))
                                    | (sec_w ? STS_BUF1_ACTIVE : STS_BUF2_ACTIVE)
                                    | STS_FRAME_STORED) & ier_w) != '0;
                                count_reg <= count_reg + 32'd1;
                            end
                        end
                    end
                    FUNC_PIXEL:
                    begin
                        if (busy_reg)
                        begin
                            kind        <= KIND_PIXEL;
                            dma_address <= row_addr_reg + col_off[33:0];
                            pixel_value <= PIXEL_ALPHA | {8'd0, pv, pv, pv};
                            pixel_bytes <= (bpp_reg < 16'd4) ? bpp_reg[2:0] : 3'd4;
                            if (row_end)
                            begin
                                col_reg      <= '0;
                                row_reg      <= row_inc;
                                row_addr_reg <= row_addr_reg + {18'd0, pitch_reg};
                                if (frame_end)
                                begin
                                    last_pixel <= 1'b1;
                                    sts_reg    <= sts_done;
                                    irq_reg    <= (sts_done & ier_w) != '0;
                                    count_reg  <= count_reg + 32'd1;
                                    busy_reg   <= 1'b0;
                                end
                            end
                            else
                            begin
                                col_reg <= col_inc;
                            end
                        end
                    end
                    default:
                    begin
                        kind <= KIND_NONE;
                    end
                endcase
            end
        end
    end

    assign irq_level = irq_reg;

endmodule

`default_nettype wire

// ===== design/capture_channel_pattern_dma.sv =====
// ----------------------------------------------------------------------------
// capture_channel_pattern_dma : capture channel with gradient pattern DMA
// Register file, frame tick handling and one pixel write per pixel slot of a frame.
// ----------------------------------------------------------------------------
// Channel | Handshake          | Payload
// in      | in_valid/in_stall  | func, reg_index, write_data
// out     | out_valid/out_stall| kind, read_data, dma_address, pixel_value,
//         |                    | pixel_bytes, last_pixel, irq_level
//
// Every item gives exactly one result. Reads, writes, pixel slots and empty
// or ignored ticks run in the execute state, then offer the result; a tick
// that starts a frame also runs the 16-step bytes-per-pixel divider first.
// A waiting result holds while out_stall is high; the next item is accepted
// in the cycle the result is taken. Reset clears the control registers and
// the written flags of the plain storage words at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module capture_channel_pattern_dma
    import ccpd_pkg::*;
#(
    parameter int NUM_REGS = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  func,
    input  wire logic [5:0]  reg_index,
    input  wire logic [31:0] write_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       kind,
    output logic [31:0]      read_data,
    output logic [33:0]      dma_address,
    output logic [31:0]      pixel_value,
    output logic [2:0]       pixel_bytes,
    output logic             last_pixel,
    output logic             irq_level
);

    ccpd_cmd_t cmd;
    ccpd_sts_t sts;
    logic      in_take;

    assign in_take = in_valid && !in_stall;

    ccpd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    ccpd_dp #(
        .NUM_REGS (NUM_REGS)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_take     (in_take),
        .func        (func),
        .reg_index   (reg_index),
        .write_data  (write_data),
        .cmd         (cmd),
        .sts         (sts),
        .kind        (kind),
        .read_data   (read_data),
        .dma_address (dma_address),
        .pixel_value (pixel_value),
        .pixel_bytes (pixel_bytes),
        .last_pixel  (last_pixel),
        .irq_level   (irq_level)
    );

endmodule

`default_nettype wire

// ===== verif/tb_capture_channel_pattern_dma.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_capture_channel_pattern_dma : testbench for the capture channel pattern DMA
// Drives register accesses, frame ticks and pixel slots through the valid/stall
// input channel, predicts every result in a local model of the channel and
// checks each result field by field as it leaves the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_capture_channel_pattern_dma;
    import ccpd_pkg::*;

    localparam int NREGS      = 64;
    localparam int WDOG_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] read_data;
        logic [33:0] dma_address;
        logic [31:0] pixel_value;
        logic [2:0]  pixel_bytes;
        logic        last_pixel;
        logic        irq_level;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  func = FUNC_READ;
    logic [5:0]  reg_index = '0;
    logic [31:0] write_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [31:0] read_data;
    logic [33:0] dma_address;
    logic [31:0] pixel_value;
    logic [2:0]  pixel_bytes;
    logic        last_pixel;
    logic        irq_level;

    capture_channel_pattern_dma #(.NUM_REGS(NREGS)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .reg_index(reg_index), .write_data(write_data),
        .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .read_data(read_data), .dma_address(dma_address),
        .pixel_value(pixel_value), .pixel_bytes(pixel_bytes),
        .last_pixel(last_pixel), .irq_level(irq_level)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------- model
    // Shadow copy of the channel state, advanced once per accepted item.
    logic [31:0] regs [NREGS];
    logic [31:0] frames_done;
    logic        capturing;
    logic [12:0] col_pos, row_pos, fr_w, fr_h;
    logic [15:0] bpp, pitch;
    logic [33:0] line_addr;
    logic        use_buf2;
    logic        irq_shadow;

    result_t expected_results [$];
    int          errors = 0;
    int          idle_pct = 18;     // sender idling, per cent
    int          sink_pct = 18;     // receiver stalls, per cent
    bit          sink_hold = 1'b0;  // request for one long receiver hold-off
    int          quiet_cycles = 0;

    function automatic void irq_update();
        irq_shadow = (regs[IDX_STS] & regs[IDX_IER]) != 0;
    endfunction

    function automatic void frame_finish();
        logic [31:0] s;
        s = regs[IDX_STS] & ~(STS_BUF1_ACTIVE | STS_BUF2_ACTIVE);
        s |= use_buf2 ? STS_BUF1_ACTIVE : STS_BUF2_ACTIVE;
        regs[IDX_STS] = s | STS_FRAME_STORED;
        frames_done = frames_done + 1;
        capturing = 1'b0;
        irq_update();
    endfunction

    function automatic void frame_begin();
        logic [31:0] base;
        if (!regs[IDX_CTRL][31] || capturing)
            return;
        fr_w = regs[IDX_IMG_CFG][12:0];
        fr_h = regs[IDX_IMG_CFG][28:16];
        pitch = regs[IDX_PITCH][15:0];
        use_buf2 = frames_done[0];
        base = use_buf2 ? regs[IDX_BUF2] : regs[IDX_BUF1];
        if (base != 0 && fr_w != 0 && fr_h != 0 && pitch != 0)
        begin
            bpp = (pitch / fr_w) != 0 ? 16'(pitch / fr_w) : 16'd4;
            col_pos = '0;
            row_pos = '0;
            line_addr = {2'b00, base};
            capturing = 1'b1;
        end
        else
            frame_finish();
    endfunction

    function automatic void reg_write(logic [5:0] idx, logic [31:0] val);
        logic [31:0] old;
        if (idx == IDX_STS)
        begin
            regs[idx] &= ~val;
            irq_update();
            return;
        end
        old = regs[idx];
        regs[idx] = val;
        if (idx == IDX_CTRL)
        begin
            if (val[31] && !old[31])
                frames_done = '0;
            else if (!val[31])
            begin
                capturing = 1'b0;
                irq_shadow = 1'b0;
            end
        end
        else if (idx == IDX_IER)
            irq_update();
    endfunction

    function automatic result_t channel_predict(logic [1:0] f, logic [5:0] idx,
                                                logic [31:0] d);
        result_t r;
        logic [7:0] v;
        r = '0;
        case (f)
            FUNC_READ:
            begin
                r.kind = KIND_READ;
                r.read_data = regs[idx];
            end
            FUNC_WRITE: reg_write(idx, d);
            FUNC_TICK:  frame_begin();
            default:
                if (capturing)
                begin
                    v = 8'(col_pos + row_pos + frames_done * 4);
                    r.kind = KIND_PIXEL;
                    r.dma_address = line_addr + 34'(col_pos) * 34'(bpp);
                    r.pixel_value = PIXEL_ALPHA | {8'h00, v, v, v};
                    r.pixel_bytes = bpp < 4 ? 3'(bpp) : 3'd4;
                    col_pos = col_pos + 1;
                    if (col_pos >= fr_w)
                    begin
                        col_pos = '0;
                        row_pos = row_pos + 1;
                        line_addr = line_addr + 34'(pitch);
                        if (row_pos >= fr_h)
                        begin
                            r.last_pixel = 1'b1;
                            frame_finish();
                        end
                    end
                end
        endcase
        r.irq_level = irq_shadow;
        return r;
    endfunction

    // --------------------------------------------------------------- sender
    // Offers one item, idling first at random; holds it until accepted.
    // Valid is left up at return; the next call or the drain replaces it.
    task automatic send_item(logic [1:0] f, logic [5:0] idx, logic [31:0] d);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        reg_index <= idx;
        write_data <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_results.push_back(channel_predict(f, idx, d));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (25) @(negedge clk);
    endtask

    task automatic set_frame(logic [12:0] w, logic [12:0] h, logic [15:0] p,
                             logic [31:0] b1, logic [31:0] b2);
        send_item(FUNC_WRITE, IDX_IMG_CFG, {3'b000, h, 3'b000, w});
        send_item(FUNC_WRITE, IDX_PITCH, {16'h0000, p});
        send_item(FUNC_WRITE, IDX_BUF1, b1);
        send_item(FUNC_WRITE, IDX_BUF2, b2);
    endtask

    // ------------------------------------------------------------- receiver
    // Random stalls, plus one long hold-off on request so the block backs up.
    always @(negedge clk)
    begin
        if (sink_hold)
        begin
            out_stall <= 1'b1;
            repeat (60) @(negedge clk);
            sink_hold = 1'b0;
        end
        else
            out_stall <= ($urandom_range(99) < sink_pct);
    end

    // -------------------------------------------------------------- checker
    always @(posedge clk)
    begin
        result_t e;
        if (in_valid && !in_stall || out_valid && !out_stall)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with nothing expected: kind %0d", kind);
                errors++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (kind !== e.kind)
                begin
                    $error("kind: expected %0d, got %0d", e.kind, kind);
                    errors++;
                end
                if (read_data !== e.read_data)
                begin
                    $error("read_data: expected %h, got %h", e.read_data, read_data);
                    errors++;
                end
                if (dma_address !== e.dma_address)
                begin
                    $error("dma_address: expected %h, got %h", e.dma_address, dma_address);
                    errors++;
                end
                if (pixel_value !== e.pixel_value)
                begin
                    $error("pixel_value: expected %h, got %h", e.pixel_value, pixel_value);
                    errors++;
                end
                if (pixel_bytes !== e.pixel_bytes)
                begin
                    $error("pixel_bytes: expected %0d, got %0d", e.pixel_bytes, pixel_bytes);
                    errors++;
                end
                if (last_pixel !== e.last_pixel)
                begin
                    $error("last_pixel: expected %0d, got %0d", e.last_pixel, last_pixel);
                    errors++;
                end
                if (irq_level !== e.irq_level)
                begin
                    $error("irq_level: expected %0d, got %0d", e.irq_level, irq_level);
                    errors++;
                end
            end
        end
    end

    // Watchdog: too long with no handshake on either side.
    always @(posedge clk)
    begin
        if (quiet_cycles >= WDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests
    // Register file: all-ones, all-zeros and alternating data on three plain indices, reads of each.
    task automatic test_registers();
        send_item(FUNC_WRITE, 6'd63, 32'hffff_ffff);
        send_item(FUNC_READ, 6'd63, '0);
        send_item(FUNC_WRITE, 6'd10, 32'h0000_0000);
        send_item(FUNC_READ, 6'd10, 32'hffff_ffff);
        send_item(FUNC_WRITE, 6'd20, 32'haaaa_5555);
        send_item(FUNC_READ, 6'd20, '0);
        // tick and pixel slot with the channel disabled do nothing
        send_item(FUNC_TICK, '0, '0);
        send_item(FUNC_PIXEL, '0, '0);
    endtask

    // One small frame, interrupt on, then status clear and disable.
    task automatic test_frame_and_irq();
        set_frame(13'd2, 13'd2, 16'd8, 32'h1000_0000, 32'hffff_fff0);
        send_item(FUNC_WRITE, IDX_IER, 32'hffff_ffff);
        send_item(FUNC_WRITE, IDX_CTRL, 32'h8000_0000);
        send_item(FUNC_TICK, '0, '0);
        send_item(FUNC_TICK, '0, '0);          // ignored while capturing
        repeat (4) send_item(FUNC_PIXEL, '0, '0);
        send_item(FUNC_PIXEL, '0, '0);         // no frame in progress
        send_item(FUNC_READ, IDX_STS, '0);
        send_item(FUNC_WRITE, IDX_CTRL, 32'h8000_0001);  // already on
        send_item(FUNC_TICK, '0, '0);          // second buffer, near the top of the 32-bit space
        repeat (4) send_item(FUNC_PIXEL, '0, '0);
        send_item(FUNC_WRITE, IDX_STS, STS_BUF1_ACTIVE);
        send_item(FUNC_WRITE, IDX_CTRL, '0);   // interrupt drops
        send_item(FUNC_READ, IDX_STS, '0);
        send_item(FUNC_WRITE, IDX_STS, 32'hffff_ffff);
        wait_drained();
    endtask

    // Empty frame, wide pixels and an abandoned frame.
    task automatic test_special_frames();
        send_item(FUNC_WRITE, IDX_CTRL, 32'h8000_0000);
        set_frame(13'd3, 13'd1, 16'd0, 32'h100, 32'h200);  // zero pitch
        send_item(FUNC_TICK, '0, '0);
        set_frame(13'd1, 13'd2, 16'd9, 32'h100, 32'h200);  // bpp 9
        send_item(FUNC_TICK, '0, '0);
        repeat (2) send_item(FUNC_PIXEL, '0, '0);
        set_frame(13'h1fff, 13'h1fff, 16'hffff, 32'h300, 32'h400);
        send_item(FUNC_TICK, '0, '0);
        repeat (3) send_item(FUNC_PIXEL, '0, '0);
        send_item(FUNC_WRITE, IDX_CTRL, '0);   // abandon
        send_item(FUNC_PIXEL, '0, '0);
        wait_drained();
    endtask

    // Receiver holds off while the sender keeps offering; then a drain pause.
    task automatic test_backpressure();
        sink_hold = 1'b1;
        repeat (20) send_item(FUNC_READ, 6'($urandom_range(63)), '0);
        wait_drained();
    endtask

    // Random frames with random content around them.
    task automatic test_random(int n_items);
        int sent;
        int r;
        sent = 0;
        send_item(FUNC_WRITE, IDX_IER, $urandom);
        send_item(FUNC_WRITE, IDX_CTRL, 32'h8000_0000);
        while (sent < n_items)
        begin
            if (sent > n_items / 2 && sent < n_items / 2 + 200)
            begin
                idle_pct = 0;
                sink_pct = 0;
            end
            else
            begin
                idle_pct = 18;
                sink_pct = 18;
            end
            r = $urandom_range(99);
            if (r < 70)
            begin
                set_frame(13'($urandom_range(1, 6)), 13'($urandom_range(1, 4)),
                          16'($urandom_range(1, 40)),
                          ($urandom_range(9) == 0) ? 32'h0 : $urandom,
                          ($urandom_range(9) == 0) ? 32'h0 : $urandom);
                send_item(FUNC_TICK, '0, '0);
                repeat ($urandom_range(4, 26)) send_item(FUNC_PIXEL, '0, '0);
                sent += 20;
            end
            else if (r < 80)
            begin
                send_item(FUNC_WRITE, IDX_STS, $urandom);
                send_item(FUNC_READ, IDX_STS, '0);
                sent += 2;
            end
            else if (r < 85)
            begin
                send_item(FUNC_WRITE, IDX_CTRL, {1'($urandom_range(1)), 31'($urandom)});
                sent += 1;
            end
            else if (r < 90)
            begin
                send_item(FUNC_WRITE, IDX_IER, $urandom);
                sent += 1;
            end
            else
            begin
                send_item(2'($urandom_range(3)), 6'($urandom_range(63)), $urandom);
                sent += 1;
            end
        end
        wait_drained();
    endtask

    initial
    begin
        for (int i = 0; i < NREGS; i++)
            regs[i] = '0;
        frames_done = '0;
        capturing = 1'b0;
        col_pos = '0;
        row_pos = '0;
        fr_w = '0;
        fr_h = '0;
        bpp = '0;
        pitch = '0;
        line_addr = '0;
        use_buf2 = 1'b0;
        irq_shadow = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_registers();
        test_frame_and_irq();
        test_special_frames();
        test_backpressure();
        test_random(1100);

        if (errors == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/ccpd_pkg.sv
design/ccpd_ctrl.sv
design/ccpd_dp.sv
design/capture_channel_pattern_dma.sv
verif/tb_capture_channel_pattern_dma.sv
